@@ design/bps_pkg.sv @@
// Package for the bilinear particle splat block: grid geometry, derived widths and item modes.
// Depends on nothing; imported by the top level and the testbench.
`default_nettype none
package bps_pkg;
	localparam int GRID_SIZE = 64;
	localparam int CELLS     = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int GW        = $clog2(GRID_SIZE);
	localparam int HX_W      = $clog2(GRID_SIZE) + 1;
	localparam int BIAS_W    = 16 + $clog2(GRID_SIZE) + 1;
	localparam int SUM_W     = 32;
	localparam int ENTRY_W   = 3 * SUM_W;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic MODE_SPLAT = 1'b0;
	localparam logic MODE_READ  = 1'b1;
endpackage
`default_nettype wire

@@ design/bilinear_particle_splat.sv @@
// Top level of the bilinear particle splat block: sequencer, shared multiplier, accumulators.
// Depends on bps_pkg and bps_ram.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  item     | item_valid / item_stall     | mode, pos_x, pos_y, red_frac, blue_frac,
//           |                             | cell_x, cell_y
//  result   | result_valid / result_stall | material, red_level, blue_level
//
// A splat tests each corner in ST_CHK and passes each in-grid corner through ST_RD, ST_M2,
// ST_M3 and ST_WR, using the one multiplier and the single-port accumulator memory.
// A read passes through ST_RRD (skipped for a cell outside the grid) and ST_RWR, and waits
// in ST_RWR while a previous result is stalled by result_stall. After reset a clearing pass
// writes every cell, with item_stall held high. A waiting result does not block splats.
`default_nettype none
module bilinear_particle_splat (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        mode,
	input  wire logic [15:0] pos_x,
	input  wire logic [15:0] pos_y,
	input  wire logic [16:0] red_frac,
	input  wire logic [16:0] blue_frac,
	input  wire logic [5:0]  cell_x,
	input  wire logic [5:0]  cell_y,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [16:0]      material,
	output logic [29:0]      red_level,
	output logic [29:0]      blue_level
);
	import bps_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_M2   = 4'd4;
	localparam logic [3:0] ST_M3   = 4'd5;
	localparam logic [3:0] ST_WR   = 4'd6;
	localparam logic [3:0] ST_RRD  = 4'd7;
	localparam logic [3:0] ST_RWR  = 4'd8;

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [1:0]        corner_q;
	logic [HX_W-1:0]   hx_q, hy_q;
	logic [15:0]       tx_q, ty_q;
	logic [16:0]       r_q, b_q;
	logic              oob_q;
	logic [32:0]       w2_q;
	logic [16:0]       red_inc_q, blue_inc_q;
	logic              out_valid_q;
	logic [16:0]       material_q;
	logic [29:0]       red_q, blue_q;

	logic              accept;
	logic [BIAS_W-1:0] bias_x, bias_y;
	logic [HX_W:0]     cx1, cy1;
	logic              corner_in;
	logic [GW-1:0]     gx, gy;
	logic [16:0]       wx, wy;
	logic [32:0]       mul_a;
	logic [16:0]       mul_b;
	logic [49:0]       prod;
	logic [49:0]       prod_rnd;
	logic [33:0]       w2_rnd;
	logic [16:0]       mass_inc;
	logic [ENTRY_W-1:0] rdata, wdata;
	logic              ram_en, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [SUM_W-1:0]  mass_old, red_old, blue_old;
	logic              cell_oob;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);

	assign bias_x = BIAS_W'(pos_x) * BIAS_W'(GRID_SIZE) + BIAS_W'(32768);
	assign bias_y = BIAS_W'(pos_y) * BIAS_W'(GRID_SIZE) + BIAS_W'(32768);

	// Corner column is hx + dx - 1; it lies in the grid when hx + dx is 1 to GRID_SIZE.
	assign cx1 = {1'b0, hx_q} + (HX_W+1)'(corner_q[0]);
	assign cy1 = {1'b0, hy_q} + (HX_W+1)'(corner_q[1]);
	assign corner_in = (cx1 != '0) && (cx1 <= (HX_W+1)'(GRID_SIZE))
			&& (cy1 != '0) && (cy1 <= (HX_W+1)'(GRID_SIZE));
	assign gx = GW'(cx1 - (HX_W+1)'(1));
	assign gy = GW'(cy1 - (HX_W+1)'(1));

	assign wx = corner_q[0] ? {1'b0, tx_q} : ONE_Q16 - {1'b0, tx_q};
	assign wy = corner_q[1] ? {1'b0, ty_q} : ONE_Q16 - {1'b0, ty_q};

	// The one multiplier: weight product first, then the red and blue scalings.
	always_comb begin
		case (state_q)
			ST_M2: begin
				mul_a = w2_q;
				mul_b = r_q;
			end
			ST_M3: begin
				mul_a = w2_q;
				mul_b = b_q;
			end
			default: begin
				mul_a = {16'd0, wx};
				mul_b = wy;
			end
		endcase
	end
	assign prod     = 50'(mul_a) * 50'(mul_b);
	assign prod_rnd = prod + 50'h0_0000_8000_0000;
	assign w2_rnd   = {1'b0, w2_q} + 34'd32768;
	assign mass_inc = w2_rnd[32:16];

	assign mass_old = rdata[3*SUM_W-1:2*SUM_W];
	assign red_old  = rdata[2*SUM_W-1:SUM_W];
	assign blue_old = rdata[SUM_W-1:0];

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [16:0] inc);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(inc);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	always_comb begin
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = addr_q;
		wdata    = '0;
		case (state_q)
			ST_CLR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_RD, ST_RRD: begin
				ram_en = 1'b1;
			end
			ST_WR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				wdata  = {sat_add(mass_old, mass_inc), sat_add(red_old, red_inc_q),
						sat_add(blue_old, blue_inc_q)};
			end
			ST_RWR: begin
				ram_en = !oob_q;
				ram_we = 1'b1;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	bps_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	assign cell_oob = ({3'd0, cell_x} >= 9'(GRID_SIZE)) || ({3'd0, cell_y} >= 9'(GRID_SIZE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register must be free before a new transfer is loaded.
			if (state_q == ST_RWR && (!out_valid_q || !result_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						corner_q <= '0;
						if (mode == MODE_READ) begin
							state_q <= cell_oob ? ST_RWR : ST_RRD;
						end else begin
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					if (corner_in) begin
						state_q <= ST_RD;
					end else if (corner_q == 2'd3) begin
						state_q <= ST_IDLE;
					end else begin
						corner_q <= corner_q + 2'd1;
					end
				end
				ST_RD: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_WR;
				ST_WR: begin
					corner_q <= corner_q + 2'd1;
					state_q  <= (corner_q == 2'd3) ? ST_IDLE : ST_CHK;
				end
				ST_RRD: state_q <= ST_RWR;
				ST_RWR: begin
					if (!out_valid_q || !result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			hx_q   <= bias_x[BIAS_W-1:16];
			hy_q   <= bias_y[BIAS_W-1:16];
			tx_q   <= bias_x[15:0];
			ty_q   <= bias_y[15:0];
			r_q    <= (red_frac > ONE_Q16) ? ONE_Q16 : red_frac;
			b_q    <= (blue_frac > ONE_Q16) ? ONE_Q16 : blue_frac;
			oob_q  <= cell_oob;
			addr_q <= ADDR_W'(cell_y) * ADDR_W'(GRID_SIZE) + ADDR_W'(cell_x);
		end
		if (state_q == ST_CHK) begin
			addr_q <= ADDR_W'(gy) * ADDR_W'(GRID_SIZE) + ADDR_W'(gx);
		end
		if (state_q == ST_RD) begin
			w2_q <= prod[32:0];
		end
		if (state_q == ST_M2) begin
			red_inc_q <= prod_rnd[48:32];
		end
		if (state_q == ST_M3) begin
			blue_inc_q <= prod_rnd[48:32];
		end
		if (state_q == ST_RWR && (!out_valid_q || !result_stall)) begin
			if (oob_q) begin
				material_q <= '0;
				red_q      <= '0;
				blue_q     <= '0;
			end else begin
				material_q <= (mass_old[31:2] > 30'(ONE_Q16)) ? ONE_Q16 : mass_old[18:2];
				red_q      <= red_old[31:2];
				blue_q     <= blue_old[31:2];
			end
		end
	end

	assign result_valid = out_valid_q;
	assign material     = material_q;
	assign red_level    = red_q;
	assign blue_level   = blue_q;
endmodule
`default_nettype wire

@@ design/bps_ram.sv @@
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module bps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end
endmodule
`default_nettype wire
